FILE: sv/bzs_pkg.sv
// Shared types and constants for the cubic Bezier segment generator.
`timescale 1ns / 1ps

package bzs_pkg;

	// Field and register widths
	localparam int COORD_W   = 16;
	localparam int STEP_W    = 10;
	localparam int CFG_IDX_W = 3;

	// Datapath widths: coefficients stay at or below N^3 < 2^30, products and sums
	// fit 47 signed bits, magnitudes 46 bits, quotients 16 bits.
	localparam int SQ_W     = 2 * STEP_W;
	localparam int COEF_W   = 3 * STEP_W;
	localparam int PROD_W   = 47;
	localparam int MAG_W    = PROD_W - 1;
	localparam int QUO_W    = COORD_W;

	// Step queue between front and back (depth is a power of two)
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P0_X,
		REG_P0_Y,
		REG_P1_X,
		REG_P1_Y,
		REG_P2_X,
		REG_P2_Y,
		REG_P3_X,
		REG_P3_Y
	} cfg_reg_t;

	// One classified step on its way to the back end
	typedef struct packed {
		logic [STEP_W-1:0] k;
		logic              fin;
	} step_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

endpackage

FILE: sv/bzs_queue.sv
// Short step queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module bzs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bzs_pkg::step_t     push_data,
	input  logic               pop,
	output bzs_pkg::step_t     pop_data,
	output bzs_pkg::q_status_t q_stat
);

	bzs_pkg::step_t                    entry_q [bzs_pkg::QDEPTH];
	logic [bzs_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [bzs_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [bzs_pkg::QCNT_W-1:0]        count_q;

	// Store a word at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data         = entry_q[rd_ptr_q];
	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.full      = (count_q == bzs_pkg::QCNT_W'(bzs_pkg::QDEPTH));

endmodule

FILE: sv/bzs_front.sv
// Front end: accepts input words, tracks the step counter and queues steps.
`timescale 1ns / 1ps

module bzs_front #(
	parameter int STEPS = 200
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	input  bzs_pkg::q_status_t q_stat,
	output logic               push,
	output bzs_pkg::step_t     push_data
);

	localparam logic [bzs_pkg::STEP_W-1:0] N = bzs_pkg::STEP_W'(STEPS);

	logic [bzs_pkg::STEP_W-1:0] step_q;
	logic [bzs_pkg::STEP_W-1:0] k_sel;
	logic                       fin;

	// Pick the step for this word: restart or an out-of-range count goes to zero
	always_comb begin
		k_sel = restart ? '0 : step_q;
		if (k_sel > N) begin
			k_sel = '0;
		end
	end

	assign fin            = (k_sel == N);
	assign in_ready       = !q_stat.full;
	assign push           = in_valid && in_ready;
	assign push_data.k    = k_sel;
	assign push_data.fin  = fin;

	// Advance the step counter, wrap after the final step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (push) begin
			step_q <= fin ? '0 : k_sel + 1'b1;
		end
	end

endmodule

FILE: sv/bzs_back.sv
// Back end: evaluates the curve point for a queued step and emits the segment.
`timescale 1ns / 1ps

module bzs_back #(
	parameter int STEPS = 200
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bzs_pkg::q_status_t                q_stat,
	input  bzs_pkg::step_t                    pop_data,
	output logic                              pop,
	input  logic signed [bzs_pkg::COORD_W-1:0] p0_x,
	input  logic signed [bzs_pkg::COORD_W-1:0] p0_y,
	input  logic signed [bzs_pkg::COORD_W-1:0] p1_x,
	input  logic signed [bzs_pkg::COORD_W-1:0] p1_y,
	input  logic signed [bzs_pkg::COORD_W-1:0] p2_x,
	input  logic signed [bzs_pkg::COORD_W-1:0] p2_y,
	input  logic signed [bzs_pkg::COORD_W-1:0] p3_x,
	input  logic signed [bzs_pkg::COORD_W-1:0] p3_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_start_x,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_start_y,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_end_x,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_end_y,
	output logic [bzs_pkg::STEP_W-1:0]         step_index,
	output logic                              last
);

	localparam int LANES = 2;
	localparam int NPTS  = 4;
	localparam logic [bzs_pkg::STEP_W-1:0] N       = bzs_pkg::STEP_W'(STEPS);
	localparam logic [bzs_pkg::COEF_W-1:0] DIVISOR = bzs_pkg::COEF_W'(STEPS * STEPS * STEPS);
	localparam logic [1:0]                 TRIPLE  = 2'd3;

	// Scaled reciprocal of N^3: the top quotient bits of a magnitude times it
	// give an estimate that runs at most two below the true quotient
	localparam longint DIV_L   = longint'(STEPS) * STEPS * STEPS;
	localparam int     DIV_SH  = $clog2(DIV_L + 1) - 1;
	localparam int     RCP_W   = bzs_pkg::QUO_W + 1;
	localparam int     EST_W   = bzs_pkg::QUO_W + RCP_W;
	localparam int     FIX_W   = bzs_pkg::COEF_W + 2;
	localparam longint RECIP_L = (longint'(1) << (DIV_SH + bzs_pkg::QUO_W)) / DIV_L;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);
	localparam logic [FIX_W-1:0] DIV2  = FIX_W'(2 * DIV_L);
	localparam logic [FIX_W-1:0] DIV3  = FIX_W'(3 * DIV_L);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_CUBE,
		ST_PROD,
		ST_SUM2,
		ST_SUM1,
		ST_ABS,
		ST_EST,
		ST_REM,
		ST_FIX,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [bzs_pkg::STEP_W-1:0]        k_q;
	logic                              fin_q;
	logic [bzs_pkg::STEP_W-1:0]        m;
	logic [bzs_pkg::SQ_W-1:0]          mm_q;
	logic [bzs_pkg::SQ_W-1:0]          kk_q;
	logic [bzs_pkg::COEF_W-1:0]        coef_q [NPTS];
	logic signed [bzs_pkg::COORD_W-1:0] cpt [LANES][NPTS];
	logic signed [bzs_pkg::PROD_W-1:0] prod_q [LANES][NPTS];
	logic signed [bzs_pkg::PROD_W-1:0] pair_q [LANES][2];
	logic signed [bzs_pkg::PROD_W-1:0] sum_q [LANES];
	logic                              neg_q [LANES];
	logic [bzs_pkg::MAG_W-1:0]         rem_q [LANES];
	logic [bzs_pkg::QUO_W-1:0]         quo_q [LANES];
	logic [bzs_pkg::QUO_W-1:0]         x_hi [LANES];
	logic [EST_W-1:0]                  est_full [LANES];
	logic signed [bzs_pkg::COORD_W-1:0] res [LANES];
	logic signed [bzs_pkg::COORD_W-1:0] prev_x_q;
	logic signed [bzs_pkg::COORD_W-1:0] prev_y_q;
	logic                              out_free;

	// Lane 0 carries x, lane 1 carries y
	assign cpt[0][0] = p0_x;
	assign cpt[0][1] = p1_x;
	assign cpt[0][2] = p2_x;
	assign cpt[0][3] = p3_x;
	assign cpt[1][0] = p0_y;
	assign cpt[1][1] = p1_y;
	assign cpt[1][2] = p2_y;
	assign cpt[1][3] = p3_y;

	assign m        = N - k_q;
	assign pop      = (state_q == ST_IDLE) && q_stat.not_empty;
	assign out_free = !out_valid || out_ready;

	// Estimate the quotient from the top bits of the magnitude
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			x_hi[l]     = rem_q[l][DIV_SH +: bzs_pkg::QUO_W];
			est_full[l] = EST_W'(x_hi[l] * RECIP);
		end
	end

	// Apply the sign back to the quotient magnitude (truncation toward zero)
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			res[l] = neg_q[l] ? bzs_pkg::COORD_W'(~quo_q[l] + 1'b1) : quo_q[l];
		end
	end

	// Datapath: weights, products, sums, then a reciprocal divide by N^3
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				k_q   <= pop_data.k;
				fin_q <= pop_data.fin;
			end
			ST_SQR: begin
				mm_q <= bzs_pkg::SQ_W'(m * m);
				kk_q <= bzs_pkg::SQ_W'(k_q * k_q);
			end
			ST_CUBE: begin
				coef_q[0] <= bzs_pkg::COEF_W'(mm_q * m);
				coef_q[1] <= bzs_pkg::COEF_W'(mm_q * k_q * TRIPLE);
				coef_q[2] <= bzs_pkg::COEF_W'(kk_q * m * TRIPLE);
				coef_q[3] <= bzs_pkg::COEF_W'(kk_q * k_q);
			end
			ST_PROD: begin
				for (int l = 0; l < LANES; l++) begin
					for (int j = 0; j < NPTS; j++) begin
						prod_q[l][j] <= bzs_pkg::PROD_W'($signed({1'b0, coef_q[j]}) * cpt[l][j]);
					end
				end
			end
			ST_SUM2: begin
				for (int l = 0; l < LANES; l++) begin
					pair_q[l][0] <= prod_q[l][0] + prod_q[l][1];
					pair_q[l][1] <= prod_q[l][2] + prod_q[l][3];
				end
			end
			ST_SUM1: begin
				for (int l = 0; l < LANES; l++) begin
					sum_q[l] <= pair_q[l][0] + pair_q[l][1];
				end
			end
			ST_ABS: begin
				for (int l = 0; l < LANES; l++) begin
					neg_q[l] <= sum_q[l][bzs_pkg::PROD_W-1];
					rem_q[l] <= sum_q[l][bzs_pkg::PROD_W-1] ?
						bzs_pkg::MAG_W'(-sum_q[l]) : bzs_pkg::MAG_W'(sum_q[l]);
				end
			end
			ST_EST: begin
				for (int l = 0; l < LANES; l++) begin
					quo_q[l] <= est_full[l][bzs_pkg::QUO_W +: bzs_pkg::QUO_W];
				end
			end
			ST_REM: begin
				for (int l = 0; l < LANES; l++) begin
					rem_q[l] <= rem_q[l] - bzs_pkg::MAG_W'(quo_q[l] * DIVISOR);
				end
			end
			ST_FIX: begin
				// Add back up to two units the estimate fell short by
				for (int l = 0; l < LANES; l++) begin
					if (rem_q[l] >= bzs_pkg::MAG_W'(DIV2)) begin
						quo_q[l] <= quo_q[l] + 2'd2;
					end else if (rem_q[l] >= bzs_pkg::MAG_W'(DIVISOR)) begin
						quo_q[l] <= quo_q[l] + 1'b1;
					end
				end
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer, output register and previous point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid   <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			seg_start_x <= '0;
			seg_start_y <= '0;
			seg_end_x   <= '0;
			seg_end_y   <= '0;
			step_index  <= '0;
			last        <= 1'b0;
		end else begin
			// Raise valid when a point is loaded, drop it once the word is taken
			if (state_q == ST_EMIT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR:  state_q <= ST_CUBE;
				ST_CUBE: state_q <= ST_PROD;
				ST_PROD: state_q <= ST_SUM2;
				ST_SUM2: state_q <= ST_SUM1;
				ST_SUM1: state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_EST;
				ST_EST:  state_q <= ST_REM;
				ST_REM:  state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_EMIT;
				ST_EMIT: begin
					// Hold the point until the output register frees up
					if (out_free) begin
						seg_start_x <= (k_q == '0) ? p0_x : prev_x_q;
						seg_start_y <= (k_q == '0) ? p0_y : prev_y_q;
						seg_end_x   <= res[0];
						seg_end_y   <= res[1];
						step_index  <= k_q;
						last        <= fin_q;
						prev_x_q    <= res[0];
						prev_y_q    <= res[1];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |-> (rem_q[0] < bzs_pkg::MAG_W'(DIV3)
		&& rem_q[1] < bzs_pkg::MAG_W'(DIV3)))
		else $error("quotient estimate off by more than two");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (step_index == N)))
		else $error("last flag disagrees with step index");

	a_prev_track: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (prev_x_q == seg_end_x && prev_y_q == seg_end_y))
		else $error("stored previous point differs from emitted end point");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_SQR))
		else $error("popped step not taken into the sequencer");
`endif

endmodule

FILE: sv/cubic_bezier_segment_generator_unit.sv
// Top level of the cubic Bezier segment generator: config registers, front, queue, back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready  | restart
//  out     | output    | out_valid / out_ready| seg_start_x/y, seg_end_x/y, step_index, last
//  cfg     | input     | cfg_we (no stall)    | cfg_index, cfg_data
//
// In the back end each word is popped and passes through the weight, product, sum and
// magnitude states, the divide by STEPS^3 (reciprocal estimate, remainder, correction)
// and a state that loads the output register; only then is the next step popped.
// The front queues up to two steps, so input words are taken while a result waits.
// Reset clears the control points to zero and restarts the curve at step zero.
// A stalled output holds the back end in its final state; the queue keeps filling.
`timescale 1ns / 1ps

module cubic_bezier_segment_generator_unit #(
	parameter int STEPS = 200
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_start_x,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_start_y,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_end_x,
	output logic signed [bzs_pkg::COORD_W-1:0] seg_end_y,
	output logic [bzs_pkg::STEP_W-1:0]          step_index,
	output logic                               last,
	input  logic                               cfg_we,
	input  logic [bzs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bzs_pkg::COORD_W-1:0]        cfg_data
);

	logic signed [bzs_pkg::COORD_W-1:0] p0_x_q;
	logic signed [bzs_pkg::COORD_W-1:0] p0_y_q;
	logic signed [bzs_pkg::COORD_W-1:0] p1_x_q;
	logic signed [bzs_pkg::COORD_W-1:0] p1_y_q;
	logic signed [bzs_pkg::COORD_W-1:0] p2_x_q;
	logic signed [bzs_pkg::COORD_W-1:0] p2_y_q;
	logic signed [bzs_pkg::COORD_W-1:0] p3_x_q;
	logic signed [bzs_pkg::COORD_W-1:0] p3_y_q;

	logic               push;
	logic               pop;
	bzs_pkg::step_t     push_data;
	bzs_pkg::step_t     pop_data;
	bzs_pkg::q_status_t q_stat;

	// Write the addressed control point register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_x_q <= '0;
			p0_y_q <= '0;
			p1_x_q <= '0;
			p1_y_q <= '0;
			p2_x_q <= '0;
			p2_y_q <= '0;
			p3_x_q <= '0;
			p3_y_q <= '0;
		end else if (cfg_we) begin
			unique case (bzs_pkg::cfg_reg_t'(cfg_index))
				bzs_pkg::REG_P0_X: p0_x_q <= cfg_data;
				bzs_pkg::REG_P0_Y: p0_y_q <= cfg_data;
				bzs_pkg::REG_P1_X: p1_x_q <= cfg_data;
				bzs_pkg::REG_P1_Y: p1_y_q <= cfg_data;
				bzs_pkg::REG_P2_X: p2_x_q <= cfg_data;
				bzs_pkg::REG_P2_Y: p2_y_q <= cfg_data;
				bzs_pkg::REG_P3_X: p3_x_q <= cfg_data;
				bzs_pkg::REG_P3_Y: p3_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bzs_front #(
		.STEPS (STEPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	bzs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	bzs_back #(
		.STEPS (STEPS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop_data    (pop_data),
		.pop         (pop),
		.p0_x        (p0_x_q),
		.p0_y        (p0_y_q),
		.p1_x        (p1_x_q),
		.p1_y        (p1_y_q),
		.p2_x        (p2_x_q),
		.p2_y        (p2_y_q),
		.p3_x        (p3_x_q),
		.p3_y        (p3_y_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.step_index  (step_index),
		.last        (last)
	);

endmodule
